@@ hw/rtl/ffha_pkg.sv @@
// shared types and constants of the first-fit heap allocator
package ffha_pkg;

  localparam int unsigned SIZE_W = 27;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned IN_DATA_W = 64;
  localparam int unsigned OUT_DATA_W = 96;

  // rounding granules, powers of two since rounding is done with masks
  localparam int unsigned ALIGN_BYTES = 8;
  localparam int unsigned PAGE_BYTES  = 4096;

  localparam logic [ADDR_W-1:0] BASE_RESET = 32'h0100_0000;
  localparam logic [SIZE_W-1:0] LIMIT_RESET = 27'h040_0000;
  localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_NULL     = 3'd1,
    ST_NO_SPACE = 3'd2,
    ST_UNKNOWN  = 3'd3,
    ST_DOUBLE   = 3'd4
  } status_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic {
    REG_HEAP_BASE  = 1'b0,
    REG_HEAP_LIMIT = 1'b1
  } reg_e;

  // one table entry: payload size and free mark
  typedef struct packed {
    logic              free;
    logic [SIZE_W-1:0] size;
  } entry_t;

endpackage

@@ hw/rtl/ffha_table.sv @@
// block table memory: one write and one registered read per cycle
module ffha_table #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_idx_i,
  input  ffha_pkg::entry_t         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_idx_i,
  output ffha_pkg::entry_t         rd_data_o
);
  import ffha_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_idx_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hw/rtl/first_fit_heap_allocator.sv @@
// first-fit heap allocator: sequencer over the block table with merging
//
// channel  | dir | contents
// s_axis   | in  | tuser: operation; tdata: request_size[26:0], free_address[58:27]
// m_axis   | out | tdata: result_address[31:0], status[34:32], used_bytes[61:35],
//          |     |        free_bytes[88:62]
// cfg      | in  | index 0 heap_base, 1 heap_limit
//
// each visited table entry is read, then checked, through the one table read
// port; a split moves the entries behind the hit one at a time (read, then
// write), and the merge after a free walks every entry (read, then check).
// reset empties the table at once; no clearing pass.
// input ready is low from acceptance until the result has been taken.
module first_fit_heap_allocator #(
  parameter int unsigned MAX_BLOCKS      = 64,
  parameter int unsigned HEADER_BYTES    = 12,
  parameter int unsigned MIN_SPLIT_BYTES = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [ffha_pkg::IN_DATA_W-1:0]       s_axis_tdata_i,  // request_size, free_address
  input  logic                                 s_axis_tuser_i,  // operation
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [ffha_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o,  // addr, status, used, free
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_idx_i,
  input  logic [ffha_pkg::ADDR_W-1:0]          cfg_data_i
);
  import ffha_pkg::*;

  localparam int unsigned AW   = $clog2(MAX_BLOCKS);
  localparam int unsigned CW   = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned OFFW = SIZE_W + CW + 1;
  localparam int unsigned RSW  = SIZE_W + 1;
  localparam logic [CW-1:0]   MAX_CNT   = CW'(MAX_BLOCKS);
  localparam logic [OFFW-1:0] HDR_OFF   = OFFW'(HEADER_BYTES);
  localparam logic [RSW-1:0]  ALIGN_M1  = RSW'(ALIGN_BYTES - 1);
  localparam logic [RSW-1:0]  SPLIT_MIN = RSW'(HEADER_BYTES + MIN_SPLIT_BYTES);
  localparam logic [OFFW:0]   PAGE_M1   = (OFFW + 1)'(PAGE_BYTES - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_APPEND, S_SHIFT_RD, S_SHIFT_WR,
    S_SPLIT_HI, S_SPLIT_LO, S_MRG_RD0, S_MRG_LD0, S_MRG_RD, S_MRG_CHK, S_MRG_FIN
  } state_e;

  state_e            state_q;
  logic              op_q;
  logic [RSW-1:0]    size_q;
  logic [ADDR_W-1:0] addr_q;
  logic [CW-1:0]     idx_q;
  logic [CW-1:0]     cnt_q;
  logic [CW-1:0]     w_q;
  logic [OFFW-1:0]   off_q;
  logic [SIZE_W-1:0] used_q;
  logic [SIZE_W-1:0] rem_q;
  logic [ADDR_W-1:0] base_q;
  logic [SIZE_W-1:0] limit_q;
  entry_t            cur_q;
  logic              out_valid_q;
  logic [ADDR_W-1:0] res_addr_q;
  status_e           status_q;

  logic              wr_en;
  logic [AW-1:0]     wr_idx;
  entry_t            wr_data;
  logic [AW-1:0]     rd_idx;
  entry_t            rd_data;

  logic [RSW-1:0]    req_round;
  logic [ADDR_W-1:0] pay_addr;
  logic [OFFW-1:0]   off_next;
  logic [RSW-1:0]    fit_rem;
  logic [OFFW:0]     app_end;
  logic [OFFW:0]     page_end;
  logic [SIZE_W+1:0] mrg_sum;
  logic [SIZE_W-1:0] mrg_size;
  logic [SIZE_W:0]   add_sum;
  logic [SIZE_W-1:0] add_arg;
  logic [SIZE_W-1:0] used_add;
  logic [SIZE_W-1:0] used_sub;
  logic [SIZE_W-1:0] free_bytes;

  ffha_table #(.DEPTH(MAX_BLOCKS)) u_table (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_idx_i (wr_idx),
    .wr_data_i(wr_data),
    .rd_idx_i (rd_idx),
    .rd_data_o(rd_data)
  );

  // shared datapath: offsets, addresses, fit and saturating sums
  assign req_round = (RSW'(s_axis_tdata_i[SIZE_W-1:0]) + ALIGN_M1) & ~ALIGN_M1;
  assign pay_addr  = base_q + off_q[ADDR_W-1:0] + ADDR_W'(HEADER_BYTES);
  assign off_next  = off_q + HDR_OFF + OFFW'(rd_data.size);
  assign fit_rem   = RSW'(rd_data.size) - size_q;
  assign app_end   = (OFFW + 1)'(off_q) + (OFFW + 1)'(HDR_OFF) + (OFFW + 1)'(size_q);
  assign page_end  = (app_end + PAGE_M1) & ~PAGE_M1;
  assign mrg_sum   = (SIZE_W + 2)'(cur_q.size) + (SIZE_W + 2)'(HEADER_BYTES)
                   + (SIZE_W + 2)'(rd_data.size);
  assign mrg_size  = (mrg_sum > (SIZE_W + 2)'(SIZE_MAX)) ? SIZE_MAX : mrg_sum[SIZE_W-1:0];
  assign add_sum   = (SIZE_W + 1)'(used_q) + (SIZE_W + 1)'(add_arg);
  assign used_add  = add_sum[SIZE_W] ? SIZE_MAX : add_sum[SIZE_W-1:0];
  assign used_sub  = (used_q >= rd_data.size) ? (used_q - rd_data.size) : '0;
  assign free_bytes = (used_q >= limit_q) ? '0 : (limit_q - used_q);

  // amount added to the used bytes on a successful allocate
  always_comb begin
    unique case (state_q)
      S_SCAN_CHK: add_arg = rd_data.size;
      default:    add_arg = size_q[SIZE_W-1:0];
    endcase
  end

  // table port control
  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = idx_q[AW-1:0];
    wr_data = '{free: 1'b0, size: size_q[SIZE_W-1:0]};
    rd_idx  = idx_q[AW-1:0];
    unique case (state_q)
      S_SCAN_CHK: begin
        if (op_q == OP_ALLOC) begin
          if (rd_data.free && (RSW'(rd_data.size) >= size_q) &&
              !(fit_rem >= SPLIT_MIN && cnt_q < MAX_CNT)) begin
            wr_en   = 1'b1;
            wr_data = '{free: 1'b0, size: rd_data.size};
          end
        end else if (pay_addr == addr_q && !rd_data.free) begin
          wr_en   = 1'b1;
          wr_data = '{free: 1'b1, size: rd_data.size};
        end
      end
      S_APPEND: begin
        wr_idx = cnt_q[AW-1:0];
        wr_en  = (cnt_q < MAX_CNT) && (page_end <= (OFFW + 1)'(limit_q));
      end
      S_SHIFT_RD: rd_idx = AW'(w_q - 1'b1);
      S_SHIFT_WR: begin
        wr_en   = 1'b1;
        wr_idx  = w_q[AW-1:0];
        wr_data = rd_data;
      end
      S_SPLIT_HI: begin
        wr_en   = 1'b1;
        wr_idx  = AW'(idx_q + 1'b1);
        wr_data = '{free: 1'b1, size: rem_q - SIZE_W'(HEADER_BYTES)};
      end
      S_SPLIT_LO: wr_en = 1'b1;
      S_MRG_RD0:  rd_idx = '0;
      S_MRG_CHK: begin
        wr_idx  = w_q[AW-1:0];
        wr_data = cur_q;
        wr_en   = !(cur_q.free && rd_data.free);
      end
      S_MRG_FIN: begin
        wr_en   = 1'b1;
        wr_idx  = w_q[AW-1:0];
        wr_data = cur_q;
      end
      default: ;
    endcase
  end

  // sequencer, counters and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      used_q      <= '0;
      base_q      <= BASE_RESET;
      limit_q     <= LIMIT_RESET;
      out_valid_q <= 1'b0;
      op_q        <= OP_ALLOC;
      status_q    <= ST_OK;
      res_addr_q  <= '0;
      size_q      <= '0;
      addr_q      <= '0;
      idx_q       <= '0;
      w_q         <= '0;
      off_q       <= '0;
      rem_q       <= '0;
      cur_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_HEAP_BASE:  base_q  <= cfg_data_i;
          REG_HEAP_LIMIT: limit_q <= cfg_data_i[SIZE_W-1:0];
        endcase
      end
      if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid_i && s_axis_tready_o) begin
            op_q   <= s_axis_tuser_i;
            size_q <= req_round;
            addr_q <= s_axis_tdata_i[SIZE_W +: ADDR_W];
            idx_q  <= '0;
            off_q  <= '0;
            if ((s_axis_tuser_i == OP_ALLOC && s_axis_tdata_i[SIZE_W-1:0] == '0) ||
                (s_axis_tuser_i == OP_FREE && s_axis_tdata_i[SIZE_W +: ADDR_W] == '0)) begin
              status_q    <= ST_NULL;
              res_addr_q  <= '0;
              out_valid_q <= 1'b1;
            end else if (cnt_q == '0) begin
              if (s_axis_tuser_i == OP_ALLOC) begin
                state_q <= S_APPEND;
              end else begin
                status_q    <= ST_UNKNOWN;
                res_addr_q  <= '0;
                out_valid_q <= 1'b1;
              end
            end else begin
              state_q <= S_SCAN_RD;
            end
          end
        end
        S_SCAN_RD: state_q <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          if (op_q == OP_ALLOC && rd_data.free && RSW'(rd_data.size) >= size_q) begin
            res_addr_q <= pay_addr;
            if (fit_rem >= SPLIT_MIN && cnt_q < MAX_CNT) begin
              rem_q   <= fit_rem[SIZE_W-1:0];
              w_q     <= cnt_q;
              state_q <= S_SHIFT_RD;
            end else begin
              used_q      <= used_add;
              status_q    <= ST_OK;
              out_valid_q <= 1'b1;
              state_q     <= S_IDLE;
            end
          end else if (op_q == OP_FREE && pay_addr == addr_q) begin
            res_addr_q <= '0;
            if (rd_data.free) begin
              status_q    <= ST_DOUBLE;
              out_valid_q <= 1'b1;
              state_q     <= S_IDLE;
            end else begin
              used_q  <= used_sub;
              state_q <= S_MRG_RD0;
            end
          end else begin
            off_q <= off_next;
            idx_q <= idx_q + 1'b1;
            if (idx_q + 1'b1 == cnt_q) begin
              if (op_q == OP_ALLOC) begin
                state_q <= S_APPEND;
              end else begin
                status_q    <= ST_UNKNOWN;
                res_addr_q  <= '0;
                out_valid_q <= 1'b1;
                state_q     <= S_IDLE;
              end
            end else begin
              state_q <= S_SCAN_RD;
            end
          end
        end
        S_APPEND: begin
          if (cnt_q < MAX_CNT && page_end <= (OFFW + 1)'(limit_q)) begin
            cnt_q      <= cnt_q + 1'b1;
            used_q     <= used_add;
            res_addr_q <= pay_addr;
            status_q   <= ST_OK;
          end else begin
            res_addr_q <= '0;
            status_q   <= ST_NO_SPACE;
          end
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        S_SHIFT_RD: begin
          if (w_q > idx_q + 1'b1) begin
            state_q <= S_SHIFT_WR;
          end else begin
            state_q <= S_SPLIT_HI;
          end
        end
        S_SHIFT_WR: begin
          w_q     <= w_q - 1'b1;
          state_q <= S_SHIFT_RD;
        end
        S_SPLIT_HI: state_q <= S_SPLIT_LO;
        S_SPLIT_LO: begin
          cnt_q       <= cnt_q + 1'b1;
          used_q      <= used_add;
          status_q    <= ST_OK;
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        S_MRG_RD0: state_q <= S_MRG_LD0;
        S_MRG_LD0: begin
          cur_q <= rd_data;
          w_q   <= '0;
          idx_q <= CW'(1);
          if (cnt_q == CW'(1)) begin
            state_q <= S_MRG_FIN;
          end else begin
            state_q <= S_MRG_RD;
          end
        end
        S_MRG_RD: state_q <= S_MRG_CHK;
        S_MRG_CHK: begin
          if (cur_q.free && rd_data.free) begin
            cur_q.size <= mrg_size;
          end else begin
            w_q   <= w_q + 1'b1;
            cur_q <= rd_data;
          end
          idx_q <= idx_q + 1'b1;
          if (idx_q + 1'b1 == cnt_q) begin
            state_q <= S_MRG_FIN;
          end else begin
            state_q <= S_MRG_RD;
          end
        end
        S_MRG_FIN: begin
          cnt_q       <= w_q + 1'b1;
          status_q    <= ST_OK;
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE) && !out_valid_q;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, free_bytes, used_q, status_q, res_addr_q};

endmodule

@@ hw/rtl/ffha_checker.sv @@
// port checker for the heap allocator, bound to the top level
module ffha_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [ffha_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);
  import ffha_pkg::*;

  // a waiting result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // no new request while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !m_axis_tvalid_o)
    else $error("request taken while result pending");

  // a result with any status other than OK carries a null address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[34:32] != ST_OK |-> m_axis_tdata_o[31:0] == '0)
    else $error("failed request returned an address");

  // ready is low in the cycle after a request is accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("ready stayed high after a request");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);

@@ bench/ffha_result_checker.sv @@
// checker for the heap allocator: predicts each response and compares it on the output channel
module ffha_result_checker
  import ffha_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  input  logic [IN_DATA_W-1:0]  s_tdata_i,   // request_size, free_address
  input  logic                  s_tuser_i,   // operation
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  input  logic [OUT_DATA_W-1:0] m_tdata_i,   // result_address, status, used_bytes, free_bytes
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [ADDR_W-1:0]     cfg_data_i,
  output int                    fail_cnt_o,
  output int                    pending_o
);

  localparam int NBLK = 64;
  localparam int HDR = 12;
  localparam int ALIGN = 8;
  localparam int PAGE = 4096;
  localparam int MIN_SPLIT = 16;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    status_e           st;
    logic [SIZE_W-1:0] used;
    logic [SIZE_W-1:0] avail;
  } heap_result_t;

  // model of the block table and counters
  logic [SIZE_W-1:0] blk_size [NBLK];
  logic              blk_free [NBLK];
  int                blk_cnt;
  logic [SIZE_W-1:0] in_use;
  logic [ADDR_W-1:0] base;
  logic [SIZE_W-1:0] limit;

  heap_result_t response_q[$];

  assign pending_o = response_q.size();

  function automatic logic [SIZE_W-1:0] clip27(logic [63:0] v);
    return (v > 64'(SIZE_MAX)) ? SIZE_MAX : v[SIZE_W-1:0];
  endfunction

  function automatic logic [63:0] header_at(int idx);
    logic [63:0] off;
    off = 0;
    for (int k = 0; k < idx; k++) off += HDR + blk_size[k];
    return off;
  endfunction

  function automatic logic [ADDR_W-1:0] payload_of(logic [63:0] off);
    logic [63:0] t;
    t = {32'b0, base} + off + HDR;
    return t[ADDR_W-1:0];
  endfunction

  // merge every run of adjacent free blocks
  function automatic void coalesce();
    int k;
    k = 0;
    while (k + 1 < blk_cnt) begin
      if (blk_free[k] && blk_free[k+1]) begin
        blk_size[k] = clip27(64'(blk_size[k]) + HDR + blk_size[k+1]);
        for (int j = k + 1; j + 1 < blk_cnt; j++) begin
          blk_size[j] = blk_size[j+1];
          blk_free[j] = blk_free[j+1];
        end
        blk_cnt--;
      end else begin
        k++;
      end
    end
  endfunction

  // first-fit placement, split, or append at the end
  function automatic logic [ADDR_W-1:0] place_block(logic [SIZE_W-1:0] req, output status_e st);
    logic [63:0] need, rem, off, fin, pg;
    st = ST_OK;
    if (req == 0) begin
      st = ST_NULL;
      return '0;
    end
    need = ((64'(req) + ALIGN - 1) / ALIGN) * ALIGN;
    for (int k = 0; k < blk_cnt; k++) begin
      if (blk_free[k] && 64'(blk_size[k]) >= need) begin
        rem = 64'(blk_size[k]) - need;
        if (rem >= HDR + MIN_SPLIT && blk_cnt < NBLK) begin
          for (int j = blk_cnt; j > k + 1; j--) begin
            blk_size[j] = blk_size[j-1];
            blk_free[j] = blk_free[j-1];
          end
          blk_size[k+1] = SIZE_W'(rem - HDR);
          blk_free[k+1] = 1'b1;
          blk_size[k] = SIZE_W'(need);
          blk_cnt++;
        end
        blk_free[k] = 1'b0;
        in_use = clip27(64'(in_use) + blk_size[k]);
        return payload_of(header_at(k));
      end
    end
    if (blk_cnt >= NBLK) begin
      st = ST_NO_SPACE;
      return '0;
    end
    off = header_at(blk_cnt);
    fin = off + HDR + need;
    pg = ((fin + PAGE - 1) / PAGE) * PAGE;
    if (pg > 64'(limit)) begin
      st = ST_NO_SPACE;
      return '0;
    end
    blk_size[blk_cnt] = SIZE_W'(need);
    blk_free[blk_cnt] = 1'b0;
    blk_cnt++;
    in_use = clip27(64'(in_use) + need);
    return payload_of(off);
  endfunction

  // find the block by payload address, mark free and merge
  function automatic status_e release_block(logic [ADDR_W-1:0] fa);
    logic [63:0] off;
    off = 0;
    if (fa == 0) return ST_NULL;
    for (int k = 0; k < blk_cnt; k++) begin
      if (payload_of(off) == fa) begin
        if (blk_free[k]) return ST_DOUBLE;
        blk_free[k] = 1'b1;
        in_use = (in_use >= blk_size[k]) ? in_use - blk_size[k] : '0;
        coalesce();
        return ST_OK;
      end
      off += HDR + blk_size[k];
    end
    return ST_UNKNOWN;
  endfunction

  function automatic heap_result_t serve_request(op_e op, logic [SIZE_W-1:0] req,
                                                 logic [ADDR_W-1:0] fa);
    heap_result_t r;
    status_e st;
    r.addr = '0;
    if (op == OP_ALLOC) r.addr = place_block(req, st);
    else st = release_block(fa);
    r.st = st;
    r.used = in_use;
    r.avail = (in_use >= limit) ? '0 : limit - in_use;
    return r;
  endfunction

  // watch config, responses and requests at each edge
  always @(posedge clk_i) begin : watch
    heap_result_t got, want;
    if (!rst_ni) begin
      blk_cnt = 0;
      in_use = '0;
      base = BASE_RESET;
      limit = LIMIT_RESET;
      fail_cnt_o = 0;
      response_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (reg_e'(cfg_idx_i) == REG_HEAP_BASE) base = cfg_data_i;
        else limit = cfg_data_i[SIZE_W-1:0];
      end
      if (m_tvalid_i && m_tready_i) begin
        got.addr = m_tdata_i[31:0];
        got.st = status_e'(m_tdata_i[34:32]);
        got.used = m_tdata_i[61:35];
        got.avail = m_tdata_i[88:62];
        if (response_q.size() == 0) begin
          $error("response with no request outstanding");
          fail_cnt_o++;
        end else begin
          want = response_q.pop_front();
          if (got.addr !== want.addr) begin
            $error("result_address: expected %h, got %h", want.addr, got.addr);
            fail_cnt_o++;
          end
          if (got.st !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, got.st);
            fail_cnt_o++;
          end
          if (got.used !== want.used) begin
            $error("used_bytes: expected %0d, got %0d", want.used, got.used);
            fail_cnt_o++;
          end
          if (got.avail !== want.avail) begin
            $error("free_bytes: expected %0d, got %0d", want.avail, got.avail);
            fail_cnt_o++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i)
        response_q.push_back(serve_request(op_e'(s_tuser_i), s_tdata_i[26:0], s_tdata_i[58:27]));
    end
  end

endmodule

@@ bench/tb.sv @@
// testbench top for the heap allocator: stimulus, flow control and verdict
module tb;
  import ffha_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;  // request_size, free_address
  logic                  s_axis_tuser_i = 1'b0; // operation
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;       // result_address, status, used, free
  logic                  cfg_we_i = 1'b0;
  logic                  cfg_idx_i = 1'b0;
  logic [ADDR_W-1:0]     cfg_data_i = '0;

  int fail_cnt, pending;
  int tx_idle, rx_idle, hold_req;
  int cycles, n_sent;
  int n_alloc_ok, n_free_ok, n_no_space, n_rejected;
  logic [ADDR_W-1:0] cur_base = BASE_RESET;
  logic [ADDR_W-1:0] live_q[$];
  logic [ADDR_W-1:0] freed_q[$];
  op_e               op_q[$];
  logic [ADDR_W-1:0] addr_q[$];

  first_fit_heap_allocator dut (.*);

  ffha_result_checker chk (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_axis_tvalid_i), .s_tready_i(s_axis_tready_o),
    .s_tdata_i(s_axis_tdata_i), .s_tuser_i(s_axis_tuser_i),
    .m_tvalid_i(m_axis_tvalid_o), .m_tready_i(m_axis_tready_i),
    .m_tdata_i(m_axis_tdata_o),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off on request
  always @(posedge clk_i) begin : rx
    int hold_left;
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(0, 99) >= rx_idle);
    end
  end

  // track live blocks from the responses
  always @(posedge clk_i) begin : track
    op_e op;
    logic [ADDR_W-1:0] fa;
    logic [2:0] st;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i && op_q.size() > 0) begin
      op = op_q.pop_front();
      fa = addr_q.pop_front();
      st = m_axis_tdata_o[34:32];
      if (st == ST_NO_SPACE) n_no_space++;
      else if (st != ST_OK) n_rejected++;
      if (st == ST_OK && op == OP_ALLOC) begin
        n_alloc_ok++;
        live_q.push_back(m_axis_tdata_o[31:0]);
      end
      if (st == ST_OK && op == OP_FREE) begin
        n_free_ok++;
        foreach (live_q[i]) if (live_q[i] == fa) begin
          live_q.delete(i);
          break;
        end
        freed_q.push_back(fa);
        if (freed_q.size() > 32) void'(freed_q.pop_front());
      end
    end
  end

  // offer one request and wait until it is taken
  task automatic send_request(op_e op, logic [SIZE_W-1:0] req, logic [ADDR_W-1:0] fa);
    while ($urandom_range(0, 99) < tx_idle) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= op;
    s_axis_tdata_i <= {5'b0, fa, req};
    do @(posedge clk_i); while (!s_axis_tready_o);
    op_q.push_back(op);
    addr_q.push_back(fa);
    n_sent++;
  endtask

  // stop offering and wait for every outstanding response
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || op_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [ADDR_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    // a new base moves every live block by the same offset
    if (idx == REG_HEAP_BASE) begin
      foreach (live_q[i]) live_q[i] = live_q[i] - cur_base + val;
      foreach (freed_q[i]) freed_q[i] = freed_q[i] - cur_base + val;
      cur_base = val;
    end
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return SIZE_W'($urandom_range(1, 256));
    if (r < 88) return SIZE_W'($urandom_range(1, 8192));
    if (r < 94) return SIZE_W'($urandom_range(8193, 200000));
    if (r < 97) return '0;
    return SIZE_W'($urandom);
  endfunction

  function automatic logic [ADDR_W-1:0] pick_addr();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75 && live_q.size() > 0) return live_q[$urandom_range(0, live_q.size() - 1)];
    if (r < 85 && freed_q.size() > 0) return freed_q[$urandom_range(0, freed_q.size() - 1)];
    if (r < 93) return $urandom;
    if (r < 96 || live_q.size() == 0) return '0;
    return live_q[0] + 4;
  endfunction

  task automatic random_request();
    int alloc_pct;
    alloc_pct = (live_q.size() < 8) ? 70 : 50;
    if ($urandom_range(0, 99) < alloc_pct) send_request(OP_ALLOC, pick_size(), $urandom);
    else send_request(OP_FREE, SIZE_W'($urandom), pick_addr());
  endtask

  initial begin
    int counts[5] = '{330, 330, 300, 20, 180};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    tx_idle = 36;
    rx_idle = 45;

    // directed: null cases, limits, reuse, split and merge
    send_request(OP_ALLOC, 27'd0, 32'h0);
    send_request(OP_FREE, 27'd5, 32'h0);
    send_request(OP_FREE, 27'd0, 32'h0100_000C);
    send_request(OP_ALLOC, 27'd1, 32'hFFFF_FFFF);
    send_request(OP_ALLOC, SIZE_MAX, 32'h0);
    send_request(OP_ALLOC, 27'd100, 32'h0);
    send_request(OP_FREE, SIZE_MAX, 32'h0100_000C);
    send_request(OP_FREE, 27'd0, 32'h0100_000C);
    send_request(OP_ALLOC, 27'd8, 32'h0);
    send_request(OP_ALLOC, 27'd200, 32'h0);
    send_request(OP_FREE, 27'd0, 32'h0100_0094);
    send_request(OP_ALLOC, 27'd16, 32'h0);
    send_request(OP_FREE, 27'd0, 32'h0100_0020);
    send_request(OP_FREE, 27'd0, 32'h0100_0094);
    send_request(OP_ALLOC, 27'h40_0000, 32'h0);
    send_request(OP_ALLOC, 27'h3F_E000, 32'h0);
    send_request(OP_FREE, 27'd0, 32'hFFFF_FFFF);
    drain();

    // random phases over several heap settings
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: begin
          write_reg(REG_HEAP_BASE, 32'hFFFF_F000);
          write_reg(REG_HEAP_LIMIT, 32'h0400_0000);
        end
        2: begin
          write_reg(REG_HEAP_BASE, 32'h0);
          write_reg(REG_HEAP_LIMIT, 32'd20000);
        end
        3: write_reg(REG_HEAP_LIMIT, 32'h0);
        4: begin
          write_reg(REG_HEAP_BASE, $urandom);
          write_reg(REG_HEAP_LIMIT, $urandom_range(8192, 27'h7FF_FFFF));
        end
        default: ;
      endcase
      tx_idle = (ph == 0) ? 36 : (ph == 1) ? 45 : 0;
      rx_idle = (ph == 0) ? 45 : (ph == 1) ? 36 : 0;
      for (int i = 0; i < counts[ph]; i++) begin
        if (ph == 1 && i == 50) hold_req = 400;
        if (i == 200) drain();
        // fill the table, then free a few and allocate into the holes
        if (ph < 2 && i == 120) begin
          repeat (70) send_request(OP_ALLOC, SIZE_W'($urandom_range(1, 64)), $urandom);
          drain();
          repeat (6) if (live_q.size() > 0)
            send_request(OP_FREE, 27'd0, live_q[$urandom_range(0, live_q.size() - 1)]);
          repeat (6) send_request(OP_ALLOC, SIZE_W'($urandom_range(1, 24)), 32'h0);
        end
        random_request();
      end
      drain();
    end

    repeat (500) @(posedge clk_i);
    $display("covered %0d requests: %0d allocations and %0d frees succeeded,",
             n_sent, n_alloc_ok, n_free_ok);
    $display("%0d failed for space, %0d rejected; five heap settings", n_no_space,
             n_rejected);
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
